// File: rtl/core/tqpl_pkg.sv
// Package with the shared types, constants and helpers of the triangle quantizer.
`timescale 1ns / 1ps
`default_nettype none
package tqpl_pkg;

  // Quantized coordinate width and derived sizes.
  localparam int CoordBits = 16;
  localparam logic [CoordBits-1:0] Scale = {CoordBits{1'b1}};
  localparam int NumW = 32 + CoordBits;
  localparam int LzW = $clog2(CoordBits + 1);
  // Divider takes CoordBits + 2 register stages, the level stage one more.
  localparam int Latency = CoordBits + 3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegXLower = 3'd0,
    RegXUpper = 3'd1,
    RegYLower = 3'd2,
    RegYUpper = 3'd3,
    RegZLower = 3'd4,
    RegZUpper = 3'd5
  } reg_index_t;

  // One input item: three vertices in Q16.16.
  typedef struct packed {
    logic signed [31:0] vert0_x;
    logic signed [31:0] vert0_y;
    logic signed [31:0] vert0_z;
    logic signed [31:0] vert1_x;
    logic signed [31:0] vert1_y;
    logic signed [31:0] vert1_z;
    logic signed [31:0] vert2_x;
    logic signed [31:0] vert2_y;
    logic signed [31:0] vert2_z;
  } tri_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  pop_level;
    logic [15:0] quant0_x;
    logic [15:0] quant0_y;
    logic [15:0] quant0_z;
    logic [15:0] quant1_x;
    logic [15:0] quant1_y;
    logic [15:0] quant1_z;
    logic [15:0] quant2_x;
    logic [15:0] quant2_y;
    logic [15:0] quant2_z;
  } res_t;

  // State carried by one stage of the divider.
  typedef struct packed {
    logic [NumW-1:0]      rem;
    logic [31:0]          den;
    logic [CoordBits-1:0] quo;
    logic                 zero;
    logic                 sat;
  } div_stage_t;

  // Number of leading zero bits, CoordBits when the word is zero.
  function automatic logic [LzW-1:0] lead_zeros(input logic [CoordBits-1:0] x);
    logic [LzW-1:0] n;
    logic           hit;
    n   = LzW'(CoordBits);
    hit = 1'b0;
    for (int i = CoordBits - 1; i >= 0; i--) begin
      if (!hit && x[i]) begin
        n   = LzW'(CoordBits - 1 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/triangle_quantize_pop_level.sv
// Top level of the triangle quantizer and level finder.
`timescale 1ns / 1ps
`default_nettype none
// Takes one triangle per cycle and returns its nine quantized coordinates and
// its progressive-buffer level: nine quantizers run side by side, each a
// restoring divider that settles one quotient bit per register stage,
// followed by one stage for the level.
// The whole pipeline holds while a finished result is stalled at the output;
// otherwise a new item is taken every cycle. Configuration writes are always
// ready and must be made while the pipeline is empty.
module triangle_quantize_pop_level (
  input  logic               clk,
  input  logic               rst,
  input  logic               tri_valid,
  output logic               tri_stall,
  input  tqpl_pkg::tri_t     tri_data,
  output logic               res_valid,
  input  logic               res_stall,
  output tqpl_pkg::res_t     res_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tqpl_pkg::*;

  logic signed [31:0]   bound [6];
  logic                 en;
  logic [Latency-1:0]   vld;
  logic signed [31:0]   coord [9];
  logic [CoordBits-1:0] q [9];
  logic [CoordBits-1:0] pdiff [3];
  logic [LzW-1:0]       lz [3];
  logic [LzW-1:0]       lz_max;
  logic [3:0]           level;

  assign cfg_ready = 1'b1;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound[0] <= 32'sd0;
      bound[1] <= 32'sd65536;
      bound[2] <= 32'sd0;
      bound[3] <= 32'sd65536;
      bound[4] <= 32'sd0;
      bound[5] <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegXLower: bound[0] <= cfg_data;
        RegXUpper: bound[1] <= cfg_data;
        RegYLower: bound[2] <= cfg_data;
        RegYUpper: bound[3] <= cfg_data;
        RegZLower: bound[4] <= cfg_data;
        RegZUpper: bound[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished item is held at the output.
  assign en        = !(res_valid && res_stall);
  assign tri_stall = res_valid && res_stall;
  assign res_valid = vld[Latency-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], tri_valid};
    end
  end

  assign coord[0] = tri_data.vert0_x;
  assign coord[1] = tri_data.vert0_y;
  assign coord[2] = tri_data.vert0_z;
  assign coord[3] = tri_data.vert1_x;
  assign coord[4] = tri_data.vert1_y;
  assign coord[5] = tri_data.vert1_z;
  assign coord[6] = tri_data.vert2_x;
  assign coord[7] = tri_data.vert2_y;
  assign coord[8] = tri_data.vert2_z;

  // One quantizer per coordinate.
  for (genvar i = 0; i < 9; i++) begin : g_quant
    tqpl_quant u_quant (
      .clk   (clk),
      .en    (en),
      .coord (coord[i]),
      .lower (bound[(i % 3) * 2]),
      .upper (bound[(i % 3) * 2 + 1]),
      .quant (q[i])
    );
  end

  // A pair differs at level l once any axis differs in its top l+1 bits.
  assign pdiff[0] = (q[0] ^ q[3]) | (q[1] ^ q[4]) | (q[2] ^ q[5]);
  assign pdiff[1] = (q[3] ^ q[6]) | (q[4] ^ q[7]) | (q[5] ^ q[8]);
  assign pdiff[2] = (q[0] ^ q[6]) | (q[1] ^ q[7]) | (q[2] ^ q[8]);

  // The level is the latest first-difference level over the three pairs.
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      lz[p] = lead_zeros(pdiff[p]);
    end
    lz_max = lz[0];
    if (lz[1] > lz_max) lz_max = lz[1];
    if (lz[2] > lz_max) lz_max = lz[2];
    if (lz_max >= LzW'(CoordBits)) begin
      level = 4'(CoordBits - 1);
    end else begin
      level = 4'(lz_max);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      res_data.pop_level <= level;
      res_data.quant0_x  <= 16'(q[0]);
      res_data.quant0_y  <= 16'(q[1]);
      res_data.quant0_z  <= 16'(q[2]);
      res_data.quant1_x  <= 16'(q[3]);
      res_data.quant1_y  <= 16'(q[4]);
      res_data.quant1_z  <= 16'(q[5]);
      res_data.quant2_x  <= 16'(q[6]);
      res_data.quant2_y  <= 16'(q[7]);
      res_data.quant2_z  <= 16'(q[8]);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tqpl_quant.sv
// Pipelined quantizer of one coordinate: scale and restoring division, one bit a stage.
`timescale 1ns / 1ps
`default_nettype none
module tqpl_quant (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [31:0]              coord,
  input  logic signed [31:0]              lower,
  input  logic signed [31:0]              upper,
  output logic [tqpl_pkg::CoordBits-1:0]  quant
);
  import tqpl_pkg::*;

  logic [32:0]  diff_full;
  logic [32:0]  span_full;
  logic [31:0]  dlt;
  logic [31:0]  den;
  logic         zero;
  logic [NumW-1:0] num;
  div_stage_t   stage [CoordBits+1];

  // Differences are taken one bit wider so nothing wraps.
  assign diff_full = {coord[31], coord} - {lower[31], lower};
  assign span_full = {upper[31], upper} - {lower[31], lower};

  // First stage: offsets and the zero cases.
  always_ff @(posedge clk) begin
    if (en) begin
      dlt  <= diff_full[31:0];
      den  <= span_full[31:0];
      zero <= (upper <= lower) || (coord <= lower);
    end
  end

  // Numerator times Scale as a shift and a subtract.
  assign num = {dlt, {CoordBits{1'b0}}} - NumW'(dlt);

  // Second stage: numerator and the saturation test.
  always_ff @(posedge clk) begin
    if (en) begin
      stage[0].rem  <= num;
      stage[0].den  <= den;
      stage[0].quo  <= '0;
      stage[0].zero <= zero;
      stage[0].sat  <= num >= {den, {CoordBits{1'b0}}};
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < CoordBits; k++) begin : g_div
    localparam int Bit = CoordBits - 1 - k;
    logic [NumW-1:0] trial;
    logic            take;
    div_stage_t      stage_next;
    assign trial = NumW'(stage[k].den) << Bit;
    assign take  = stage[k].rem >= trial;
    always_comb begin
      stage_next          = stage[k];
      stage_next.rem      = take ? stage[k].rem - trial : stage[k].rem;
      stage_next.quo[Bit] = take;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stage[k+1] <= stage_next;
      end
    end
  end

  // Apply the zero and saturation cases.
  always_comb begin
    if (stage[CoordBits].zero) begin
      quant = '0;
    end else if (stage[CoordBits].sat) begin
      quant = Scale;
    end else begin
      quant = stage[CoordBits].quo;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tqpl_checker.sv
// Port-level checker for the triangle quantizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tqpl_props (
  input  logic           clk,
  input  logic           rst,
  input  logic           tri_stall,
  input  logic           res_valid,
  input  logic           res_stall,
  input  tqpl_pkg::res_t res_data
);
  import tqpl_pkg::*;

  // A stalled result item stays offered.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("result payload changed while stalled");

  // The input side holds exactly when the output holds.
  assert property (@(posedge clk) disable iff (rst)
    tri_stall == (res_valid && res_stall))
    else $error("input stall out of step with output stall");

  // Nothing comes out right after reset.
  assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result item right after reset");

  // Two identical vertices leave the triangle degenerate at every level.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.quant0_x == res_data.quant1_x &&
    res_data.quant0_y == res_data.quant1_y &&
    res_data.quant0_z == res_data.quant1_z |-> res_data.pop_level == 4'(CoordBits - 1))
    else $error("level too low for coincident vertices");

endmodule

bind triangle_quantize_pop_level tqpl_props u_tqpl_props (
  .clk       (clk),
  .rst       (rst),
  .tri_stall (tri_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);
`default_nettype wire

// File: verif/tqpl_checker.sv
// Checker for the triangle quantizer: predicts each result and compares it.
`timescale 1ns / 1ps
module tqpl_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            tri_valid,
  input  logic            tri_stall,
  input  tqpl_pkg::tri_t  tri_data,
  input  logic            res_valid,
  input  logic            res_stall,
  input  tqpl_pkg::res_t  res_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output int              fail_count,
  output int              pending,
  output int              tris_taken,
  output int              results_taken,
  output int              writes_taken
);
  import tqpl_pkg::*;

  localparam longint FullScale = (longint'(1) << CoordBits) - 1;

  // Axis bounds as the block should hold them, lower and upper per axis.
  longint axis_lo[3];
  longint axis_hi[3];
  res_t   expected_results[$];

  // Quantizes one coordinate against one axis, saturating to the full scale.
  function automatic logic [15:0] quantize_coord(longint v, longint lo, longint hi);
    longint q;
    if (hi <= lo || v <= lo) return 16'd0;
    q = ((v - lo) * FullScale) / (hi - lo);
    if (q > FullScale) q = FullScale;
    return 16'(q);
  endfunction

  // Builds the full result of one triangle: quantized vertices and level.
  function automatic res_t predict_triangle(tri_t t);
    logic [31:0] c[9];
    logic [15:0] q[9];
    res_t        r;
    logic        degen;
    int          sh;
    {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]} = t;
    for (int i = 0; i < 9; i++)
      q[i] = quantize_coord(longint'($signed(c[i])), axis_lo[i % 3], axis_hi[i % 3]);
    r.pop_level = 4'(CoordBits - 1);
    for (int l = CoordBits - 1; l >= 0; l--) begin
      sh = CoordBits - 1 - l;
      degen = 1'b0;
      for (int a = 0; a < 3; a++) begin
        for (int b = a + 1; b < 3; b++) begin
          if ((q[3*a] >> sh) == (q[3*b] >> sh) &&
              (q[3*a+1] >> sh) == (q[3*b+1] >> sh) &&
              (q[3*a+2] >> sh) == (q[3*b+2] >> sh))
            degen = 1'b1;
        end
      end
      // Walking downward, the last non-degenerate level seen is the first one.
      if (!degen) r.pop_level = 4'(l);
    end
    {r.quant0_x, r.quant0_y, r.quant0_z, r.quant1_x, r.quant1_y, r.quant1_z,
     r.quant2_x, r.quant2_y, r.quant2_z} = {q[0], q[1], q[2], q[3], q[4], q[5],
                                            q[6], q[7], q[8]};
    return r;
  endfunction

  // Compares one result with the oldest expectation, field by field.
  task automatic compare_result(res_t got, res_t want);
    logic [15:0] g[10];
    logic [15:0] w[10];
    string       names[10];
    names = '{"pop_level", "quant0_x", "quant0_y", "quant0_z", "quant1_x",
              "quant1_y", "quant1_z", "quant2_x", "quant2_y", "quant2_z"};
    g[0] = 16'(got.pop_level);
    w[0] = 16'(want.pop_level);
    {g[1], g[2], g[3], g[4], g[5], g[6], g[7], g[8], g[9]} = got[143:0];
    {w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9]} = want[143:0];
    for (int i = 0; i < 10; i++) begin
      if (g[i] !== w[i]) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                   results_taken, names[i], w[i], g[i]);
      end
    end
  endtask

  // Track writes, accepted triangles and results at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      axis_lo = '{0, 0, 0};
      axis_hi = '{65536, 65536, 65536};
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        writes_taken++;
        if (cfg_index <= RegZUpper) begin
          if (cfg_index[0]) axis_hi[cfg_index >> 1] = longint'($signed(cfg_data));
          else axis_lo[cfg_index >> 1] = longint'($signed(cfg_data));
        end
      end
      if (tri_valid && !tri_stall) begin
        tris_taken++;
        expected_results.insert(expected_results.size(), predict_triangle(tri_data));
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Result %0d arrived with none expected", results_taken);
        end else begin
          compare_result(res_data, expected_results.pop_front());
        end
        results_taken++;
      end
    end
    pending = expected_results.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    tris_taken = 0;
    results_taken = 0;
    writes_taken = 0;
  end
endmodule

// File: verif/tb.sv
// Testbench top for the triangle quantizer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
  import tqpl_pkg::*;

  localparam logic [2:0] RegUnusedA = 3'd6;
  localparam logic [2:0] RegUnusedB = 3'd7;
  localparam int WatchdogLimit = 4000;
  localparam longint MinQ = -longint'(1) <<< 31;
  localparam longint MaxQ = (longint'(1) << 31) - 1;

  logic        clk;
  logic        rst;
  logic        tri_valid;
  logic        tri_stall;
  tri_t        tri_data;
  logic        res_valid;
  logic        res_stall;
  res_t        res_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          tris_taken;
  int          results_taken;
  int          writes_taken;
  int          quiet_cycles;
  bit          idling_on;
  longint      cur_lo[3];
  longint      cur_hi[3];

  triangle_quantize_pop_level DUT (.*);
  tqpl_checker checker_i (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if ((tri_valid && !tri_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver side: a random stall before each result, sometimes none at all.
  initial begin
    int n;
    int seen;
    res_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = idling_on ? $urandom_range(0, 10) : 0;
      repeat (n) begin
        res_stall = 1'b1;
        @(negedge clk);
      end
      res_stall = 1'b0;
      seen = results_taken;
      @(negedge clk);
      while (results_taken == seen) @(negedge clk);
    end
  end

  // Writes one register and waits for the write to be taken.
  task automatic write_reg(logic [2:0] idx, longint val);
    int seen;
    seen = writes_taken;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 32'(val);
    @(negedge clk);
    while (writes_taken == seen) @(negedge clk);
    cfg_valid = 1'b0;
    if (idx <= RegZUpper) begin
      if (idx[0]) cur_hi[idx >> 1] = longint'($signed(32'(val)));
      else cur_lo[idx >> 1] = longint'($signed(32'(val)));
    end
  endtask

  // Lets the pipeline drain completely before a configuration change.
  task automatic drain;
    tri_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
  endtask

  task automatic set_bounds(longint xl, longint xh, longint yl, longint yh,
                            longint zl, longint zh);
    drain();
    write_reg(RegXLower, xl);
    write_reg(RegXUpper, xh);
    write_reg(RegYLower, yl);
    write_reg(RegYUpper, yh);
    write_reg(RegZLower, zl);
    write_reg(RegZUpper, zh);
  endtask

  // Sends one triangle after a random gap; valid stays high between items
  // when the gap is zero.
  task automatic send_tri(longint c[9]);
    int n;
    int seen;
    n = idling_on ? $urandom_range(0, 10) : 0;
    if (n > 0) begin
      tri_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    tri_valid = 1'b1;
    tri_data = {32'(c[0]), 32'(c[1]), 32'(c[2]), 32'(c[3]), 32'(c[4]),
                32'(c[5]), 32'(c[6]), 32'(c[7]), 32'(c[8])};
    seen = tris_taken;
    @(negedge clk);
    while (tris_taken == seen) @(negedge clk);
  endtask

  // A coordinate inside an axis range, with some picks on or past its ends.
  function automatic longint pick_in_range(int axis);
    longint span;
    span = cur_hi[axis] - cur_lo[axis];
    case ($urandom_range(0, 9))
      0: return cur_lo[axis];
      1: return cur_hi[axis];
      2: return longint'($signed($urandom));
      default: begin
        if (span <= 0) return longint'($signed($urandom));
        return cur_lo[axis] + longint'({$urandom, $urandom} % (span + 1));
      end
    endcase
  endfunction

  // Random triangle: mostly two vertices close to a third, so that deep
  // levels are reached, plus fully random and in-range noise.
  task automatic send_random_tri;
    longint c[9];
    longint d;
    int     mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode == 0) c[i] = longint'($signed($urandom));
      else if (mode == 1 || i < 3) c[i] = pick_in_range(i % 3);
      else if ($urandom_range(0, 7) == 0) c[i] = c[i % 3];
      else begin
        d = longint'($urandom_range(0, 32'hFFFFFF)) >> $urandom_range(0, 24);
        c[i] = $urandom_range(0, 1) ? c[i % 3] + d : c[i % 3] - d;
        if (c[i] > MaxQ) c[i] = MaxQ;
        if (c[i] < MinQ) c[i] = MinQ;
      end
    end
    send_tri(c);
  endtask

  task automatic send_random_batch(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) idling_on = (i % 120 == 0);
      send_random_tri();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    longint c[9];
    rst = 1'b1;
    tri_valid = 1'b0;
    tri_data = '0;
    cfg_valid = 1'b0;
    cfg_index = RegXLower;
    cfg_data = '0;
    quiet_cycles = 0;
    idling_on = 1'b1;
    cur_lo = '{0, 0, 0};
    cur_hi = '{65536, 65536, 65536};
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed triangles under the reset bounds.
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_tri(c);
    c = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
    send_tri(c);
    c = '{MinQ, MinQ, MinQ, MaxQ, MaxQ, MaxQ, 65536, 65536, 65536};
    send_tri(c);
    c = '{MaxQ, MinQ, 32768, MaxQ, MinQ, 32768, 1, 2, 3};
    send_tri(c);
    c = '{1, 1, 1, 2, 2, 2, 3, 3, 3};
    send_tri(c);
    c = '{-1, 65537, 65535, 32768, 32768, 32768, 32769, 32768, 32768};
    send_tri(c);
    c = '{12345, 23456, 34567, 12345, 23456, 34568, 40000, 50000, 60000};
    send_tri(c);
    c = '{-65536, 131072, 0, 65535, 1, 65536, 0, 65536, 1};
    send_tri(c);

    // Writes to unused indexes must not disturb the bounds.
    drain();
    write_reg(RegUnusedA, 32'hDEAD_BEEF);
    write_reg(RegUnusedB, 32'h8000_0000);
    c = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
    send_tri(c);
    send_random_batch(270);

    // Full signed range on every axis.
    set_bounds(MinQ, MaxQ, MinQ, MaxQ, MinQ, MaxQ);
    c = '{MinQ, MinQ, MinQ, MaxQ, MaxQ, MaxQ, 0, 0, 0};
    send_tri(c);
    c = '{MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ - 1, MaxQ, MaxQ};
    send_tri(c);
    send_random_batch(270);

    // Inverted, empty and one-step ranges.
    set_bounds(100, -100, 5, 5, 0, 1);
    c = '{-200, 5, 0, 200, 6, 1, 0, 4, 2};
    send_tri(c);
    c = '{MaxQ, MaxQ, MaxQ, MinQ, MinQ, MinQ, 0, 5, 1};
    send_tri(c);
    send_random_batch(270);

    // Assorted narrow and one-sided ranges.
    set_bounds(-65536, 65536, 1000, 1000 + 65535, MinQ, 0);
    c = '{-65536, 1000, MinQ, 65536, 66535, 0, 0, 33767, -1};
    send_tri(c);
    send_random_batch(270);

    // Two rounds of random bounds.
    for (int r = 0; r < 2; r++) begin
      longint b[6];
      for (int a = 0; a < 3; a++) begin
        b[2*a] = longint'($signed($urandom));
        b[2*a+1] = b[2*a] + (longint'($urandom) >> $urandom_range(0, 31));
        if (b[2*a+1] > MaxQ) b[2*a+1] = MaxQ;
      end
      set_bounds(b[0], b[1], b[2], b[3], b[4], b[5]);
      send_random_batch(270);
    end

    // Back to the reset values.
    set_bounds(0, 65536, 0, 65536, 0, 65536);
    send_random_batch(100);

    tri_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);

    $display("Checked %0d triangles under seven bound settings, with %0d register writes.",
             results_taken, writes_taken);
    $display("Coverage included saturation, empty and inverted ranges, and unused indexes.");
    if (fail_count == 0 && results_taken == tris_taken)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
